@@ src/jsu_pkg.sv @@
// shared types and character constants for the json string unescaper
// no dependencies; imported by every module of the block
`default_nettype none

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PKT_BYTES   = 6;

    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_B      = 16'h0062;
    localparam logic [15:0] CH_F      = 16'h0066;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_R      = 16'h0072;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_U      = 16'h0075;

    localparam logic [15:0] CTL_BS  = 16'h0008;
    localparam logic [15:0] CTL_FF  = 16'h000C;
    localparam logic [15:0] CTL_LF  = 16'h000A;
    localparam logic [15:0] CTL_CR  = 16'h000D;
    localparam logic [15:0] CTL_TAB = 16'h0009;

    localparam logic [7:0] REP_B0 = 8'hEF;
    localparam logic [7:0] REP_B1 = 8'hBF;
    localparam logic [7:0] REP_B2 = 8'hBD;

    // everything one input word turns into
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] data;
        logic [2:0]                nbytes;
        logic                      has_status;
        logic                      status_code;
    } jsu_pkt_t;

endpackage

`default_nettype wire

@@ src/jsu_front.sv @@
// front end: takes code units, runs the escape state machine and utf-8 encoder
// depends on jsu_pkg; pushes one packet per productive word into jsu_fifo
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        first_unit,
    input  wire logic        last_unit,
    input  wire logic        queue_full,
    output logic             push,
    output jsu_pkt_t         pkt
);

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_BODY = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX1 = 7'b0001000,
        MODE_HEX2 = 7'b0010000,
        MODE_HEX3 = 7'b0100000,
        MODE_HEX4 = 7'b1000000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] hex_reg, hex_next;
    logic [9:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        do_put;
    logic [15:0] put_val;
    logic        st;
    logic        st_code;
    logic        pre_rep;
    logic [3:0][7:0] main_b;
    logic [2:0]  main_n;
    logic [4:0]  digit;
    logic [20:0] cp;

    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[16'h0030:16'h0039]})
            r = {1'b1, c[3:0]};
        else if (c inside {[16'h0061:16'h0066], [16'h0041:16'h0046]})
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign digit    = hex_digit(code_unit);

    always_comb
    begin
        mode_next       = mode_reg;
        hex_next        = hex_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        err_next        = err_reg;
        do_put          = 1'b0;
        put_val         = '0;
        st              = 1'b0;
        st_code         = 1'b0;
        pre_rep         = 1'b0;
        main_b          = '0;
        main_n          = '0;
        cp              = '0;
        if (accept)
        begin
            if (first_unit)
            begin
                hex_next        = '0;
                held_next       = '0;
                held_valid_next = 1'b0;
                err_next        = (code_unit != CH_QUOTE);
                mode_next       = MODE_BODY;
                if (last_unit)
                begin
                    st        = 1'b1;
                    st_code   = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            else if (mode_reg == MODE_IDLE)
            begin
                if (last_unit)
                begin
                    st      = 1'b1;
                    st_code = 1'b1;
                end
            end
            else if (last_unit)
            begin
                if (err_reg || mode_reg != MODE_BODY || code_unit != CH_QUOTE)
                    st_code = 1'b1;
                else if (held_valid_reg)
                    pre_rep = 1'b1;
                held_valid_next = 1'b0;
                st              = 1'b1;
                mode_next       = MODE_IDLE;
            end
            else if (!err_reg)
            begin
                case (mode_reg)
                    MODE_BODY:
                    begin
                        if (code_unit == CH_BSLASH)
                            mode_next = MODE_ESC;
                        else
                        begin
                            do_put  = 1'b1;
                            put_val = code_unit;
                        end
                    end
                    MODE_ESC:
                    begin
                        mode_next = MODE_BODY;
                        do_put    = 1'b1;
                        case (code_unit)
                            CH_QUOTE:  put_val = CH_QUOTE;
                            CH_BSLASH: put_val = CH_BSLASH;
                            CH_SLASH:  put_val = CH_SLASH;
                            CH_B:      put_val = CTL_BS;
                            CH_F:      put_val = CTL_FF;
                            CH_N:      put_val = CTL_LF;
                            CH_R:      put_val = CTL_CR;
                            CH_T:      put_val = CTL_TAB;
                            CH_U:
                            begin
                                do_put    = 1'b0;
                                mode_next = MODE_HEX1;
                                hex_next  = '0;
                            end
                            default:
                            begin
                                do_put   = 1'b0;
                                err_next = 1'b1;
                            end
                        endcase
                    end
                    MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
                    begin
                        if (!digit[4])
                        begin
                            err_next  = 1'b1;
                            mode_next = MODE_BODY;
                        end
                        else
                        begin
                            hex_next = {hex_reg[11:0], digit[3:0]};
                            case (mode_reg)
                                MODE_HEX1: mode_next = MODE_HEX2;
                                MODE_HEX2: mode_next = MODE_HEX3;
                                MODE_HEX3: mode_next = MODE_HEX4;
                                default:
                                begin
                                    mode_next = MODE_BODY;
                                    do_put    = 1'b1;
                                    put_val   = {hex_reg[11:0], digit[3:0]};
                                end
                            endcase
                        end
                    end
                    default: mode_next = MODE_IDLE;
                endcase
            end

            // utf-16 to utf-8 with surrogate pairing
            if (do_put)
            begin
                if (held_valid_reg)
                begin
                    held_valid_next = 1'b0;
                    if (put_val inside {[16'hDC00:16'hDFFF]})
                        cp = {1'b0, held_reg, put_val[9:0]} + 21'h10000;
                    else
                        pre_rep = 1'b1;
                end
                if (held_valid_reg && put_val inside {[16'hDC00:16'hDFFF]})
                begin
                    main_b[0] = {5'b11110, cp[20:18]};
                    main_b[1] = {2'b10, cp[17:12]};
                    main_b[2] = {2'b10, cp[11:6]};
                    main_b[3] = {2'b10, cp[5:0]};
                    main_n    = 3'd4;
                end
                else if (put_val inside {[16'hD800:16'hDBFF]})
                begin
                    held_next       = put_val[9:0];
                    held_valid_next = 1'b1;
                end
                else if (put_val inside {[16'hDC00:16'hDFFF]})
                begin
                    main_b[0] = REP_B0;
                    main_b[1] = REP_B1;
                    main_b[2] = REP_B2;
                    main_n    = 3'd3;
                end
                else if (put_val < 16'h0080)
                begin
                    main_b[0] = put_val[7:0];
                    main_n    = 3'd1;
                end
                else if (put_val < 16'h0800)
                begin
                    main_b[0] = {3'b110, put_val[10:6]};
                    main_b[1] = {2'b10, put_val[5:0]};
                    main_n    = 3'd2;
                end
                else
                begin
                    main_b[0] = {4'b1110, put_val[15:12]};
                    main_b[1] = {2'b10, put_val[11:6]};
                    main_b[2] = {2'b10, put_val[5:0]};
                    main_n    = 3'd3;
                end
            end
        end
    end

    always_comb
    begin
        pkt.has_status  = st;
        pkt.status_code = st_code;
        if (pre_rep)
        begin
            pkt.data   = {main_b[2], main_b[1], main_b[0], REP_B2, REP_B1, REP_B0};
            pkt.nbytes = main_n + 3'd3;
        end
        else
        begin
            pkt.data   = {16'h0000, main_b[3], main_b[2], main_b[1], main_b[0]};
            pkt.nbytes = main_n;
        end
    end

    assign push = accept && (st || pre_rep || main_n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            hex_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            hex_reg        <= hex_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            err_reg        <= err_next;
        end
    end

    // a held half never survives the end of a literal
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> !held_valid_reg)
        else $error("held surrogate while idle");

    // after an error the escape machine is parked in the body or idle
    a_err_parked: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (mode_reg == MODE_BODY || mode_reg == MODE_IDLE))
        else $error("escape state active after error");

endmodule

`default_nettype wire

@@ src/jsu_fifo.sv @@
// short packet queue between the decode front end and the byte emitter
// depends on jsu_pkg for the packet type
`default_nettype none

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire jsu_pkt_t push_pkt,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output jsu_pkt_t      head_pkt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkt_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underflow");

endmodule

`default_nettype wire

@@ src/jsu_emit.sv @@
// back end: walks the head packet and sends one word per cycle, while the
// receiver is ready, through an output register; depends on jsu_pkg
`default_nettype none

module jsu_emit
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire jsu_pkt_t   head_pkt,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic [1:0] user_reg;
    logic       last_reg;

    logic       load;
    logic       is_byte;
    logic       is_last;

    assign load    = head_valid && (!valid_reg || m_tready);
    assign is_byte = (idx_reg < head_pkt.nbytes);
    assign is_last = head_pkt.has_status ? (idx_reg == head_pkt.nbytes)
                                         : (idx_reg == head_pkt.nbytes - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= is_byte ? head_pkt.data[idx_reg] : 8'h00;
            user_reg <= is_byte ? 2'b00 : {head_pkt.status_code, 1'b1};
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // a packet is walked only from its start
    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == 3'd0))
        else $error("item index left over with empty queue");

endmodule

`default_nettype wire

@@ src/json_string_unescape_utf8_top.sv @@
// json string literal unescaper, utf-16 code units in, utf-8 bytes out
// depends on jsu_pkg, jsu_front, jsu_fifo, jsu_emit
//
// usage:
//   slave side takes one utf-16 code unit per word: tdata is the unit, tuser
//   flags the opening unit, tlast flags the closing unit. master side sends
//   one word per result: tdata is a utf-8 byte, tuser marks a status word
//   and carries its code (1 = not a valid string), tlast marks the final
//   word caused by one input word. on a status code of 1 the bytes of that
//   literal are to be thrown away.
//   an accepted input word goes into the packet queue, and its first result
//   word then passes the emitter's output register onto m_tvalid. the emitter
//   sends one word per cycle while the receiver is ready; an input word gives
//   one to six result words; a word with none pushes nothing. a four-entry
//   packet queue between the decoder and the emitter lets input flow on while
//   bytes drain. reset empties the queue and output register and waits for an
//   opening quote. a stalled receiver holds the output word; input keeps
//   being taken until the queue fills, then s_tready drops.
`default_nettype none

module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // code_unit
    input  wire logic        s_tuser,   // first_unit
    input  wire logic        s_tlast,   // last_unit
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [1:0]       m_tuser,   // status_code, is_status
    output logic             m_tlast    // last_of_run
);

    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    jsu_pkt_t push_pkt;
    jsu_pkt_t head_pkt;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_unit  (s_tdata),
        .first_unit (s_tuser),
        .last_unit  (s_tlast),
        .queue_full (full),
        .push       (push),
        .pkt        (push_pkt)
    );

    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_pkt   (push_pkt),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_pkt   (head_pkt)
    );

    jsu_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pkt   (head_pkt),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
